// ===== sv/wrm_pkg.sv =====
// Package: shared types, constants and helpers for the windowed rate meter.
package wrm_pkg;

  localparam int SLOTS = 10;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int USEC_PER_SEC = 1000000;
  localparam int SLOT_USEC = USEC_PER_SEC / SLOTS;
  localparam logic [19:0] USEC_MAX = 20'd999999;
  localparam logic [31:0] DEF_SHORT = 32'd3600;
  localparam logic [31:0] DEF_MEDIUM = 32'd86400;
  localparam logic [31:0] DEF_LONG = 32'd2592000;
  localparam int NPEAK = 3;

  typedef enum logic [1:0] {
    CFG_SHORT  = 2'd0,
    CFG_MEDIUM = 2'd1,
    CFG_LONG   = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAP,
    ST_WALK,
    ST_ADD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_CROSS,
    ST_CMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [19:0] usec);
    logic [SLOT_W-1:0] s;
    s = '0;
    for (int i = 1; i < SLOTS; i++) begin
      if (usec >= 20'(i * SLOT_USEC)) s = SLOT_W'(i);
    end
    return s;
  endfunction

endpackage

// ===== sv/wrm_if.sv =====
// Valid/ready channel interface carrying a transaction payload.
interface wrm_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/wrm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module wrm_div import wrm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, quo_r[31]} - {1'b0, dvs_r};
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) dvs_r <= req.divisor;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
endmodule

// ===== sv/windowed_rate_meter_with_peaks.sv =====
// Top level: sliding one-second rate meter with short, medium and long peak hold.
// One transaction in, one out. A query or an ignored feed goes from ST_GAP straight to
// the divisions, a feed after a gap of a second or more passes ST_ADD first, and any
// other feed walks the expired buckets in ST_WALK (up to SLOTS-1) before ST_ADD. Six
// serial divisions on the shared bit-serial divider set the pace. A new item is
// accepted only after the previous result has been taken.
module windowed_rate_meter_with_peaks import wrm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_time_sec,
  input  logic [19:0] in_time_usec,
  input  logic [31:0] in_increment,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_window_speed,
  output logic [31:0] out_peak_short_speed,
  output logic [31:0] out_peak_short_sec,
  output logic [19:0] out_peak_short_usec,
  output logic [31:0] out_peak_medium_speed,
  output logic [31:0] out_peak_medium_sec,
  output logic [19:0] out_peak_medium_usec,
  output logic [31:0] out_peak_long_speed,
  output logic [31:0] out_peak_long_sec,
  output logic [19:0] out_peak_long_usec,
  output logic        out_ignored
);
  state_t state_r, state_nxt;
  logic [31:0] period_r [NPEAK];
  logic [31:0] slot_r [SLOTS];
  logic [31:0] wsum_r, last_sec_r, pv_r [NPEAK], ps_r [NPEAK];
  logic [19:0] last_usec_r, pu_r [NPEAK];
  logic        act_r, ign_r;
  logic [31:0] sec_r, inc_r, rem_r, speed_r, qa_r;
  logic [19:0] usec_r;
  logic [SLOT_W-1:0] idx_r, cur_r;
  logic [2:0]  dsel_r;
  logic [NPEAK-1:0] cross_r;
  logic        gap_big;
  logic [33:0] dsec;
  logic        older;
  div_req_t dreq;
  div_rsp_t drsp;

  wrm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ready = (state_r == ST_IDLE) && !out_valid;
  assign dsec = {2'b0, sec_r} - {2'b0, last_sec_r};
  always_comb begin
    if (dsec[33]) gap_big = 1'b0;
    else if (dsec[31:0] >= 32'd2) gap_big = 1'b1;
    else if (dsec[31:0] == 32'd1) gap_big = usec_r >= last_usec_r;
    else gap_big = 1'b0;
  end
  assign older = (sec_r < last_sec_r) || (sec_r == last_sec_r && usec_r < last_usec_r);

  always_comb begin
    dreq.start = (state_r == ST_DIV_START);
    dreq.dividend = dsel_r[0] ? ps_r[dsel_r[2:1]] : sec_r;
    dreq.divisor = period_r[dsel_r[2:1]];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && in_ready) state_nxt = ST_GAP;
      ST_GAP: begin
        if (act_r || older) state_nxt = ST_DIV_START;
        else if (gap_big) state_nxt = ST_ADD;
        else state_nxt = ST_WALK;
      end
      ST_WALK: if (idx_r == cur_r) state_nxt = ST_ADD;
      ST_ADD: state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (drsp.done) state_nxt = dsel_r[0] ? ST_CROSS : ST_DIV_START;
      ST_CROSS: state_nxt = (dsel_r[2:1] == 2'd2) ? ST_CMP : ST_DIV_START;
      ST_CMP: state_nxt = ST_OUT;
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid <= 1'b0;
      period_r[0] <= DEF_SHORT;
      period_r[1] <= DEF_MEDIUM;
      period_r[2] <= DEF_LONG;
      for (int i = 0; i < SLOTS; i++) slot_r[i] <= '0;
      wsum_r <= '0;
      last_sec_r <= '0;
      last_usec_r <= '0;
      for (int k = 0; k < NPEAK; k++) begin
        pv_r[k] <= '0;
        ps_r[k] <= '0;
        pu_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHORT: period_r[0] <= (cfg_data != 0) ? cfg_data : DEF_SHORT;
          CFG_MEDIUM: period_r[1] <= (cfg_data != 0) ? cfg_data : DEF_MEDIUM;
          CFG_LONG: period_r[2] <= (cfg_data != 0) ? cfg_data : DEF_LONG;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_valid && in_ready) begin
          act_r <= in_action;
          sec_r <= in_time_sec;
          usec_r <= (in_time_usec > USEC_MAX) ? USEC_MAX : in_time_usec;
          inc_r <= in_increment;
        end
        ST_GAP: begin
          cur_r <= slot_of(usec_r);
          idx_r <= slot_of(last_usec_r);
          rem_r <= '0;
          dsel_r <= '0;
          ign_r <= !act_r && older;
          speed_r <= act_r ? (gap_big ? 32'd0 : wsum_r) : wsum_r;
          qa_r <= 32'd0;
          if (!act_r && !older && gap_big) begin
            for (int i = 0; i < SLOTS; i++) slot_r[i] <= '0;
            wsum_r <= '0;
          end
        end
        ST_WALK: if (idx_r != cur_r) begin
          idx_r <= (32'(idx_r) + 1 >= SLOTS) ? '0 : idx_r + 1'b1;
          rem_r <= rem_r + slot_r[(32'(idx_r) + 1 >= SLOTS) ? '0 : idx_r + 1'b1];
          slot_r[(32'(idx_r) + 1 >= SLOTS) ? '0 : idx_r + 1'b1] <= '0;
        end
        ST_ADD: begin
          slot_r[cur_r] <= slot_r[cur_r] + inc_r;
          wsum_r <= wsum_r + inc_r - rem_r;
          speed_r <= wsum_r + inc_r - rem_r;
          last_sec_r <= sec_r;
          last_usec_r <= usec_r;
        end
        ST_DIV_WAIT: if (drsp.done) begin
          if (!dsel_r[0]) begin
            qa_r <= drsp.quot;
            dsel_r <= dsel_r + 3'd1;
          end else cross_r[dsel_r[2:1]] <= qa_r > drsp.quot;
        end
        ST_CROSS: dsel_r <= dsel_r + 3'd1;
        ST_CMP: begin
          // peak speed used by refresh: feed uses new sum, query uses 0
          if (!(ign_r) && cross_r[0]) begin
            pv_r[0] <= '0;
            if (cross_r[1]) begin
              pv_r[1] <= act_r ? 32'd0 : speed_r;
              ps_r[1] <= sec_r;
              pu_r[1] <= usec_r;
              if (cross_r[2]) begin
                pv_r[2] <= act_r ? 32'd0 : speed_r;
                ps_r[2] <= sec_r;
                pu_r[2] <= usec_r;
              end
            end
          end
        end
        ST_OUT: begin
          if (!ign_r && !act_r && speed_r > pv_r[0]) begin
            pv_r[0] <= speed_r;
            ps_r[0] <= sec_r;
            pu_r[0] <= usec_r;
            if (speed_r > pv_r[1]) begin
              pv_r[1] <= speed_r;
              ps_r[1] <= sec_r;
              pu_r[1] <= usec_r;
              if (speed_r > pv_r[2]) begin
                pv_r[2] <= speed_r;
                ps_r[2] <= sec_r;
                pu_r[2] <= usec_r;
              end
            end
          end
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  logic upd0, upd1, upd2;
  assign upd0 = !ign_r && !act_r && speed_r > pv_r[0];
  assign upd1 = upd0 && speed_r > pv_r[1];
  assign upd2 = upd1 && speed_r > pv_r[2];

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT) begin
      out_window_speed <= speed_r;
      out_ignored <= ign_r;
      out_peak_short_speed <= upd0 ? speed_r : pv_r[0];
      out_peak_short_sec <= upd0 ? sec_r : ps_r[0];
      out_peak_short_usec <= upd0 ? usec_r : pu_r[0];
      out_peak_medium_speed <= upd1 ? speed_r : pv_r[1];
      out_peak_medium_sec <= upd1 ? sec_r : ps_r[1];
      out_peak_medium_usec <= upd1 ? usec_r : pu_r[1];
      out_peak_long_speed <= upd2 ? speed_r : pv_r[2];
      out_peak_long_sec <= upd2 ? sec_r : ps_r[2];
      out_peak_long_usec <= upd2 ? usec_r : pu_r[2];
    end
  end
endmodule

// ===== tb/sv/windowed_rate_meter_with_peaks_test.sv =====
// Testbench for the windowed rate meter: directed table, random phases, scoreboard check.
module windowed_rate_meter_with_peaks_test import wrm_pkg::*; ();

  typedef struct packed {
    logic        action;
    logic [31:0] sec;
    logic [19:0] usec;
    logic [31:0] inc;
  } meter_in_t;

  typedef struct packed {
    logic [31:0] window_speed;
    logic [31:0] s_speed;
    logic [31:0] s_sec;
    logic [19:0] s_usec;
    logic [31:0] m_speed;
    logic [31:0] m_sec;
    logic [19:0] m_usec;
    logic [31:0] l_speed;
    logic [31:0] l_sec;
    logic [19:0] l_usec;
    logic        ignored;
  } meter_out_t;

  typedef struct {
    logic        action;
    logic [31:0] sec;
    logic [19:0] usec;
    logic [31:0] inc;
    bit          typed;
    logic [31:0] speed;
    logic        ign;
  } table_row_t;

  typedef struct {
    bit          typed;
    logic [31:0] speed;
    logic        ign;
  } typed_t;

  localparam logic ACT_FEED  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;
  localparam int   IDLE_LIMIT = 3000;
  localparam int   DRAIN = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SHORT;
  logic [31:0] cfg_data = '0;

  wrm_if #(.T(meter_in_t))  feed_ch ();
  wrm_if #(.T(meter_out_t)) rate_ch ();

  windowed_rate_meter_with_peaks i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (feed_ch.valid),
    .in_ready              (feed_ch.ready),
    .in_action             (feed_ch.data.action),
    .in_time_sec           (feed_ch.data.sec),
    .in_time_usec          (feed_ch.data.usec),
    .in_increment          (feed_ch.data.inc),
    .out_valid             (rate_ch.valid),
    .out_ready             (rate_ch.ready),
    .out_window_speed      (rate_ch.data.window_speed),
    .out_peak_short_speed  (rate_ch.data.s_speed),
    .out_peak_short_sec    (rate_ch.data.s_sec),
    .out_peak_short_usec   (rate_ch.data.s_usec),
    .out_peak_medium_speed (rate_ch.data.m_speed),
    .out_peak_medium_sec   (rate_ch.data.m_sec),
    .out_peak_medium_usec  (rate_ch.data.m_usec),
    .out_peak_long_speed   (rate_ch.data.l_speed),
    .out_peak_long_sec     (rate_ch.data.l_sec),
    .out_peak_long_usec    (rate_ch.data.l_usec),
    .out_ignored           (rate_ch.data.ignored)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // meter shadow state
  logic [31:0] bucket [SLOTS];
  logic [31:0] win_sum;
  logic [31:0] feed_sec;
  logic [19:0] feed_usec;
  logic [31:0] pk_val [NPEAK];
  logic [31:0] pk_sec [NPEAK];
  logic [19:0] pk_usec [NPEAK];
  logic [31:0] period [NPEAK];

  meter_out_t speed_q [$];
  typed_t     typed_q [$];
  int         errors = 0;
  int         idle_cycles = 0;
  bit         calm = 1'b0;
  int         jump_max = 8000;
  logic [31:0] cur_sec = '0;
  logic [19:0] cur_usec = '0;

  function automatic int bucket_of(logic [19:0] usec);
    int w;
    int s;
    w = USEC_PER_SEC / SLOTS;
    s = (w == 0) ? 0 : int'(usec) / w;
    if (s >= SLOTS) s = SLOTS - 1;
    return s;
  endfunction

  function automatic longint gap_from_feed(logic [31:0] sec, logic [19:0] usec);
    return (longint'(sec) - longint'(feed_sec)) * USEC_PER_SEC
           + longint'(usec) - longint'(feed_usec);
  endfunction

  function automatic bit crossed(int k, logic [31:0] sec);
    return (sec / period[k]) > (pk_sec[k] / period[k]);
  endfunction

  function automatic void hold_peak(int k, logic [31:0] v, logic [31:0] s, logic [19:0] u);
    pk_val[k] = v;
    pk_sec[k] = s;
    pk_usec[k] = u;
  endfunction

  function automatic void update_peaks(logic [31:0] v, logic [31:0] s, logic [19:0] u);
    if (crossed(0, s)) begin
      pk_val[0] = '0;
      if (crossed(1, s)) begin
        hold_peak(1, v, s, u);
        if (crossed(2, s)) hold_peak(2, v, s, u);
      end
    end
    if (v > pk_val[0]) begin
      hold_peak(0, v, s, u);
      if (v > pk_val[1]) begin
        hold_peak(1, v, s, u);
        if (v > pk_val[2]) hold_peak(2, v, s, u);
      end
    end
  endfunction

  function automatic meter_out_t meter_step(meter_in_t t);
    meter_out_t  r;
    logic [19:0] u;
    logic [31:0] removed;
    int          cur;
    int          i;
    u = (t.usec > USEC_MAX) ? USEC_MAX : t.usec;
    r = '0;
    if (t.action == ACT_FEED) begin
      if (t.sec < feed_sec || (t.sec == feed_sec && u < feed_usec)) begin
        r.ignored = 1'b1;
      end else begin
        cur = bucket_of(u);
        removed = '0;
        if (gap_from_feed(t.sec, u) >= USEC_PER_SEC) begin
          foreach (bucket[j]) bucket[j] = '0;
          win_sum = '0;
        end else begin
          i = bucket_of(feed_usec);
          while (i != cur) begin
            i = (i + 1 >= SLOTS) ? 0 : i + 1;
            removed += bucket[i];
            bucket[i] = '0;
          end
        end
        bucket[cur] += t.inc;
        win_sum = win_sum + t.inc - removed;
        update_peaks(win_sum, t.sec, u);
        feed_sec = t.sec;
        feed_usec = u;
      end
      r.window_speed = win_sum;
    end else begin
      update_peaks('0, t.sec, u);
      r.window_speed = (gap_from_feed(t.sec, u) >= USEC_PER_SEC) ? '0 : win_sum;
    end
    r.s_speed = pk_val[0]; r.s_sec = pk_sec[0]; r.s_usec = pk_usec[0];
    r.m_speed = pk_val[1]; r.m_sec = pk_sec[1]; r.m_usec = pk_usec[1];
    r.l_speed = pk_val[2]; r.l_sec = pk_sec[2]; r.l_usec = pk_usec[2];
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) report(field, got, want);
  endtask

  // scoreboard and watchdog
  always @(posedge clk) begin
    meter_out_t want;
    meter_out_t got;
    typed_t     ty;
    bit         moved;
    moved = 1'b0;
    if (rst_n) begin
      if (feed_ch.valid && feed_ch.ready) begin
        moved = 1'b1;
        want = meter_step(feed_ch.data);
        ty = typed_q.pop_front();
        if (ty.typed) begin
          want.window_speed = ty.speed;
          want.ignored = ty.ign;
        end
        speed_q.push_back(want);
      end
      if (rate_ch.valid && rate_ch.ready) begin
        moved = 1'b1;
        got = rate_ch.data;
        if (speed_q.size() == 0) begin
          report("unexpected transaction", '0, '0);
        end else begin
          want = speed_q.pop_front();
          check_field("window_speed", got.window_speed, want.window_speed);
          check_field("peak_short_speed", got.s_speed, want.s_speed);
          check_field("peak_short_sec", got.s_sec, want.s_sec);
          check_field("peak_short_usec", 32'(got.s_usec), 32'(want.s_usec));
          check_field("peak_medium_speed", got.m_speed, want.m_speed);
          check_field("peak_medium_sec", got.m_sec, want.m_sec);
          check_field("peak_medium_usec", 32'(got.m_usec), 32'(want.m_usec));
          check_field("peak_long_speed", got.l_speed, want.l_speed);
          check_field("peak_long_sec", got.l_sec, want.l_sec);
          check_field("peak_long_usec", 32'(got.l_usec), 32'(want.l_usec));
          check_field("ignored", 32'(got.ignored), 32'(want.ignored));
        end
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    rate_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        rate_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rate_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rate_ch.valid && rst_n));
    end
  end

  task automatic send(meter_in_t t, typed_t ty);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      feed_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_q.push_back(ty);
    feed_ch.valid <= 1'b1;
    feed_ch.data <= t;
    do @(posedge clk); while (!feed_ch.ready);
  endtask

  task automatic write_periods(logic [31:0] ps, logic [31:0] pm, logic [31:0] pl);
    logic [31:0] v [NPEAK];
    v[0] = ps; v[1] = pm; v[2] = pl;
    feed_ch.valid <= 1'b0;
    wait (speed_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    for (int k = 0; k < NPEAK; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(k);
      cfg_data <= v[k];
      @(posedge clk);
      if (v[k] != 0) period[k] = v[k];
      else period[k] = (k == 0) ? DEF_SHORT : (k == 1) ? DEF_MEDIUM : DEF_LONG;
    end
    cfg_we <= 1'b0;
  endtask

  task automatic make_item(output meter_in_t t);
    int r;
    int q;
    logic [31:0] d;
    r = $urandom_range(0, 99);
    t.inc = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
    if (r < 4) begin
      t.action = 1'($urandom_range(0, 1));
      t.sec = $urandom;
      t.usec = 20'($urandom_range(0, 20'hFFFFF));
      if (t.sec > cur_sec || (t.sec == cur_sec && t.usec >= cur_usec)) t.action = ACT_QUERY;
    end else if (r < 10) begin
      t.action = (cur_sec > 0) ? ACT_FEED : ACT_QUERY;
      t.sec = (cur_sec > 0) ? cur_sec - 1 : cur_sec;
      t.usec = 20'($urandom_range(0, 20'hFFFFF));
    end else if (r < 25) begin
      t.action = ACT_QUERY;
      t.sec = cur_sec + $urandom_range(0, 2);
      t.usec = 20'($urandom_range(0, USEC_MAX));
    end else begin
      t.action = ACT_FEED;
      q = $urandom_range(0, 9);
      if (q < 8) begin
        d = (q < 6) ? $urandom_range(0, 250000) : $urandom_range(900000, 1100000);
        d = d + cur_usec;
        cur_sec = cur_sec + d / USEC_PER_SEC;
        cur_usec = 20'(d % USEC_PER_SEC);
      end else begin
        cur_sec = cur_sec + $urandom_range(1, jump_max);
        cur_usec = 20'($urandom_range(0, USEC_MAX));
      end
      t.sec = cur_sec;
      t.usec = cur_usec;
      if ($urandom_range(0, 19) == 0) begin
        cur_usec = USEC_MAX;
        t.usec = 20'($urandom_range(USEC_MAX, 20'hFFFFF));
      end
    end
  endtask

  task automatic run_random(int n);
    meter_in_t t;
    typed_t    none;
    none = '{typed: 1'b0, speed: '0, ign: 1'b0};
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      make_item(t);
      send(t, none);
    end
    calm = 1'b0;
  endtask

  table_row_t opening [] = '{
    '{ACT_QUERY, 32'd0, 20'd0, 32'd0, 1, 32'd0, 1'b0},
    '{ACT_FEED, 32'd0, 20'd0, 32'd5, 1, 32'd5, 1'b0},
    '{ACT_FEED, 32'd0, 20'd500000, 32'hFFFFFFFF, 1, 32'd4, 1'b0},
    '{ACT_FEED, 32'd0, 20'd100000, 32'd77, 1, 32'd4, 1'b1},
    '{ACT_QUERY, 32'd0, 20'd900000, 32'd0, 1, 32'd4, 1'b0},
    '{ACT_QUERY, 32'd0, 20'd0, 32'd0, 1, 32'd4, 1'b0},
    '{ACT_FEED, 32'd0, 20'hFFFFF, 32'd1, 1, 32'd5, 1'b0},
    '{ACT_FEED, 32'd1, 20'd50000, 32'd3, 0, 32'd0, 1'b0},
    '{ACT_FEED, 32'd1, 20'd450000, 32'd2, 0, 32'd0, 1'b0},
    '{ACT_QUERY, 32'd3, 20'd0, 32'd0, 1, 32'd0, 1'b0},
    '{ACT_FEED, 32'd3600, 20'd0, 32'd7, 1, 32'd7, 1'b0},
    '{ACT_FEED, 32'd3600, 20'd999999, 32'd1, 0, 32'd0, 1'b0},
    '{ACT_QUERY, 32'd7300, 20'd10, 32'd0, 1, 32'd0, 1'b0},
    '{ACT_FEED, 32'd86400, 20'd0, 32'd9, 1, 32'd9, 1'b0},
    '{ACT_FEED, 32'd2592000, 20'd0, 32'd1, 1, 32'd1, 1'b0},
    '{ACT_FEED, 32'd2592000, 20'd950000, 32'd0, 1, 32'd1, 1'b0}
  };

  table_row_t closing [] = '{
    '{ACT_FEED, 32'hFFFFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1'b0},
    '{ACT_QUERY, 32'hFFFFFFFF, 20'd999999, 32'd0, 1, 32'hFFFFFFFF, 1'b0},
    '{ACT_FEED, 32'd0, 20'd0, 32'd1, 1, 32'hFFFFFFFF, 1'b1},
    '{ACT_QUERY, 32'hFFFFFFFF, 20'd0, 32'd0, 1, 32'hFFFFFFFF, 1'b0}
  };

  task automatic run_table(table_row_t rows []);
    meter_in_t t;
    typed_t    ty;
    foreach (rows[i]) begin
      t = '{action: rows[i].action, sec: rows[i].sec, usec: rows[i].usec, inc: rows[i].inc};
      ty = '{typed: rows[i].typed, speed: rows[i].speed, ign: rows[i].ign};
      send(t, ty);
    end
  endtask

  initial begin
    feed_ch.valid = 1'b0;
    feed_ch.data = '0;
    foreach (bucket[j]) bucket[j] = '0;
    win_sum = '0;
    feed_sec = '0;
    feed_usec = '0;
    for (int k = 0; k < NPEAK; k++) hold_peak(k, '0, '0, '0);
    period[0] = DEF_SHORT;
    period[1] = DEF_MEDIUM;
    period[2] = DEF_LONG;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_table(opening);
    cur_sec = 32'd2592000;
    cur_usec = 20'd950000;

    write_periods(32'd1, 32'd1, 32'd1);
    jump_max = 3;
    run_random(150);

    write_periods(32'd5, 32'd20, 32'd60);
    jump_max = 40;
    run_random(250);

    write_periods(32'd0, 32'd0, 32'd0);
    jump_max = 5000;
    run_random(150);

    write_periods($urandom_range(2, 30), $urandom_range(31, 200), $urandom_range(201, 900));
    jump_max = 300;
    run_random(200);

    write_periods(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    jump_max = 20000;
    cur_sec = 32'hC0000000 | $urandom_range(0, 32'h0FFFFFFF);
    cur_usec = 20'($urandom_range(0, USEC_MAX));
    run_random(200);

    run_table(closing);
    feed_ch.valid <= 1'b0;

    wait (speed_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (speed_q.size() != 0) report("missing transaction", 32'(speed_q.size()), '0);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
